>>> hw/rtl/kruskal_mst_engine_assert.svh
// assertion macros for the spanning tree engine
`ifndef KRUSKAL_MST_ENGINE_ASSERT_SVH
`define KRUSKAL_MST_ENGINE_ASSERT_SVH

// checked property, ignored while reset is high
`define KME_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kme check failed");

// checked property, also evaluated through reset
`define KME_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("kme check failed");

`endif

>>> hw/rtl/kme_pkg.sv
package kme_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int FILL_W    = EDGE_AW + 1;
   localparam int WT_W      = 16;
   localparam int RANK_W    = 3;

   localparam logic [RANK_W-1:0] RANK_MAX      = '1;
   localparam logic [CNT_W-1:0]  NODE_CNT_INIT = CNT_W'(MAX_NODES);

   typedef struct packed {
      logic [NODE_W-1:0]      src_node;
      logic [NODE_W-1:0]      dst_node;
      logic signed [WT_W-1:0] edge_weight;
      logic                   last_edge;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]      tree_src;
      logic [NODE_W-1:0]      tree_dst;
      logic signed [WT_W-1:0] tree_weight;
      logic                   overflowed;
      logic                   last_result;
   } rsp_type;

   // one stored edge, endpoints ordered low then high
   typedef struct packed {
      logic [NODE_W-1:0]      src;
      logic [NODE_W-1:0]      dst;
      logic signed [WT_W-1:0] wt;
   } edge_type;

   // one disjoint-set entry
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } uf_node_type;

   typedef enum logic [1:0] {
      UF_FIND,
      UF_JOIN,
      UF_CLEAR
   } uf_op_type;

   typedef struct packed {
      logic              valid;
      uf_op_type         op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } uf_cmd_type;

   typedef struct packed {
      logic ready;
      logic differ;
   } uf_sts_type;

endpackage

>>> hw/rtl/kme_ram.sv
module kme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/kme_uf.sv
module kme_uf (
   input  logic                clock,
   input  logic                reset,
   input  kme_pkg::uf_cmd_type cmd,
   output kme_pkg::uf_sts_type sts
);

   typedef enum logic [2:0] {
      U_CLEAR,
      U_IDLE,
      U_FRD,
      U_FCHK,
      U_JOIN2
   } state_type;

   state_type                     state_ff;
   logic [kme_pkg::NODE_W-1:0]    cnt_ff;
   logic [kme_pkg::NODE_W-1:0]    r_ff;
   logic [kme_pkg::NODE_W-1:0]    nb_ff;
   logic                          second_ff;
   logic [kme_pkg::NODE_W-1:0]    ra_ff;
   logic [kme_pkg::NODE_W-1:0]    rb_ff;
   logic [kme_pkg::RANK_W-1:0]    rka_ff;
   logic [kme_pkg::RANK_W-1:0]    rkb_ff;
   logic                          differ_ff;

   logic                          wr_en;
   logic [kme_pkg::NODE_W-1:0]    wr_addr;
   kme_pkg::uf_node_type          wr_data;
   kme_pkg::uf_node_type          rd_data;
   logic [kme_pkg::RANK_W-1:0]    rka_inc;

   assign rka_inc = (rka_ff == kme_pkg::RANK_MAX) ? rka_ff : rka_ff + 1'b1;

   // set entries, rank and parent side by side
   kme_ram #(
      .WIDTH ($bits(kme_pkg::uf_node_type)),
      .DEPTH (kme_pkg::MAX_NODES)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (r_ff),
      .rd_data (rd_data)
   );

   // write port: clearing sweep and union by rank
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ra_ff;
      wr_data = '{rank: rka_ff, parent: rb_ff};
      case (state_ff)
         U_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '{rank: '0, parent: cnt_ff};
         end
         U_IDLE: begin
            if (cmd.valid && cmd.op == kme_pkg::UF_JOIN) begin
               wr_en = 1'b1;
               if (rka_ff < rkb_ff) begin
                  wr_addr = ra_ff;
                  wr_data = '{rank: rka_ff, parent: rb_ff};
               end else begin
                  wr_addr = rb_ff;
                  wr_data = '{rank: rkb_ff, parent: ra_ff};
               end
            end
         end
         U_JOIN2: begin
            wr_en   = 1'b1;
            wr_addr = ra_ff;
            wr_data = '{rank: rka_inc, parent: ra_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequencer: root walk of both endpoints, joins, clearing
   // chains never exceed the rank bound, so no compression is needed for the roots
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= U_CLEAR;
         cnt_ff    <= '0;
         differ_ff <= 1'b0;
      end else begin
         case (state_ff)
            U_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == kme_pkg::NODE_W'(kme_pkg::MAX_NODES - 1)) begin
                  state_ff <= U_IDLE;
               end
            end
            U_IDLE: begin
               if (cmd.valid) begin
                  case (cmd.op)
                     kme_pkg::UF_FIND: begin
                        r_ff      <= cmd.node_a;
                        nb_ff     <= cmd.node_b;
                        second_ff <= 1'b0;
                        state_ff  <= U_FRD;
                     end
                     kme_pkg::UF_JOIN: begin
                        if (rka_ff == rkb_ff) begin
                           state_ff <= U_JOIN2;
                        end
                     end
                     kme_pkg::UF_CLEAR: begin
                        cnt_ff   <= '0;
                        state_ff <= U_CLEAR;
                     end
                     default: begin
                        state_ff <= U_IDLE;
                     end
                  endcase
               end
            end
            U_FRD: begin
               state_ff <= U_FCHK;
            end
            U_FCHK: begin
               if (rd_data.parent == r_ff) begin
                  if (!second_ff) begin
                     ra_ff     <= r_ff;
                     rka_ff    <= rd_data.rank;
                     r_ff      <= nb_ff;
                     second_ff <= 1'b1;
                     state_ff  <= U_FRD;
                  end else begin
                     rb_ff     <= r_ff;
                     rkb_ff    <= rd_data.rank;
                     differ_ff <= (ra_ff != r_ff);
                     state_ff  <= U_IDLE;
                  end
               end else begin
                  r_ff     <= rd_data.parent;
                  state_ff <= U_FRD;
               end
            end
            U_JOIN2: begin
               state_ff <= U_IDLE;
            end
            default: begin
               state_ff <= U_CLEAR;
            end
         endcase
      end
   end

   assign sts.ready  = (state_ff == U_IDLE);
   assign sts.differ = differ_ff;

endmodule

>>> hw/rtl/kruskal_mst_engine.sv
// after the last request, each stored edge taken in weight order costs one selection
//    pass over the edge memory plus a root walk of both endpoints and, for a tree edge, a join
// throughput: one request per cycle while loading; no request is taken during a run
// the pass over the edge memory is the shared unit that sets the run length; stalls add on
// reset: synchronous, node_count back to 64, then a clearing pass over all 64 entries of the
//    set memory (repeated after every run) before requests are taken
module kruskal_mst_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kme_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kme_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [kme_pkg::CNT_W-1:0]       csr_wr_data
);

   typedef enum logic [3:0] {
      T_CLEAR,
      T_LOAD,
      T_CHECK,
      T_SCAN,
      T_FIND,
      T_EMIT,
      T_JOIN,
      T_FINISH,
      T_LAST_EMIT,
      T_RESTART
   } state_type;

   state_type                       state_ff;
   logic [kme_pkg::CNT_W-1:0]       node_count_ff;
   logic [kme_pkg::FILL_W-1:0]      fill_ff;
   logic                            drop_ff;
   logic [kme_pkg::NODE_W-1:0]      target_ff;
   logic [kme_pkg::NODE_W-1:0]      taken_ff;
   logic [kme_pkg::FILL_W-1:0]      iter_ff;
   logic [kme_pkg::FILL_W-1:0]      scan_ff;
   logic                            rd_vld_ff;
   logic [kme_pkg::EDGE_AW-1:0]     rd_idx_ff;
   logic                            found_ff;
   kme_pkg::edge_type               best_ff;
   logic [kme_pkg::EDGE_AW-1:0]     best_idx_ff;
   logic                            have_last_ff;
   logic signed [kme_pkg::WT_W-1:0] last_wt_ff;
   logic [kme_pkg::EDGE_AW-1:0]     last_idx_ff;
   logic                            pend_vld_ff;
   kme_pkg::edge_type               pend_ff;
   logic                            rsp_valid_ff;
   kme_pkg::rsp_type                rsp_data_ff;

   logic [kme_pkg::CNT_W-1:0]       nodes;
   logic                            edge_ok;
   logic                            store_full;
   logic                            accept;
   logic                            edge_wr;
   kme_pkg::edge_type               edge_new;
   kme_pkg::edge_type               edge_rd;
   logic                            edge_fresh;
   logic                            scan_done;
   kme_pkg::uf_cmd_type             uf_cmd;
   kme_pkg::uf_sts_type             uf_sts;

   // edge admission
   assign nodes = (node_count_ff > kme_pkg::NODE_CNT_INIT) ? kme_pkg::NODE_CNT_INIT
                                                           : node_count_ff;
   assign edge_ok = (req_data.src_node != req_data.dst_node)
                 && ({1'b0, req_data.src_node} < nodes)
                 && ({1'b0, req_data.dst_node} < nodes);
   assign store_full = (fill_ff == kme_pkg::FILL_W'(kme_pkg::MAX_EDGES));
   assign req_ready  = (state_ff == T_LOAD);
   assign accept     = req_valid && req_ready;
   assign edge_wr    = accept && edge_ok && !store_full;

   always_comb begin
      edge_new.wt = req_data.edge_weight;
      if (req_data.src_node < req_data.dst_node) begin
         edge_new.src = req_data.src_node;
         edge_new.dst = req_data.dst_node;
      end else begin
         edge_new.src = req_data.dst_node;
         edge_new.dst = req_data.src_node;
      end
   end

   kme_ram #(
      .WIDTH ($bits(kme_pkg::edge_type)),
      .DEPTH (kme_pkg::MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (fill_ff[kme_pkg::EDGE_AW-1:0]),
      .wr_data (edge_new),
      .rd_addr (scan_ff[kme_pkg::EDGE_AW-1:0]),
      .rd_data (edge_rd)
   );

   // only edges after the previous pick in weight then load order are candidates
   assign edge_fresh = !have_last_ff
                    || (edge_rd.wt > last_wt_ff)
                    || ((edge_rd.wt == last_wt_ff) && (rd_idx_ff > last_idx_ff));

   // selection pass is over once every read has been compared
   assign scan_done = (scan_ff == fill_ff) && !rd_vld_ff;

   // commands to the disjoint-set unit
   always_comb begin
      uf_cmd.valid  = 1'b0;
      uf_cmd.op     = kme_pkg::UF_FIND;
      uf_cmd.node_a = best_ff.src;
      uf_cmd.node_b = best_ff.dst;
      case (state_ff)
         T_SCAN: begin
            uf_cmd.valid = scan_done;
         end
         T_JOIN: begin
            uf_cmd.valid = 1'b1;
            uf_cmd.op    = kme_pkg::UF_JOIN;
         end
         T_RESTART: begin
            uf_cmd.valid = 1'b1;
            uf_cmd.op    = kme_pkg::UF_CLEAR;
         end
         default: begin
            uf_cmd.valid = 1'b0;
         end
      endcase
   end

   kme_uf u_uf (
      .clock (clock),
      .reset (reset),
      .cmd   (uf_cmd),
      .sts   (uf_sts)
   );

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= kme_pkg::NODE_CNT_INIT;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // main sequencer: load, select next edge in sort order, test, emit, join
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         have_last_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         case (state_ff)
            T_CLEAR: begin
               if (uf_sts.ready) begin
                  state_ff <= T_LOAD;
               end
            end
            T_LOAD: begin
               if (accept) begin
                  if (edge_ok) begin
                     if (store_full) begin
                        drop_ff <= 1'b1;
                     end else begin
                        fill_ff <= fill_ff + 1'b1;
                     end
                  end
                  if (req_data.last_edge) begin
                     target_ff    <= (nodes == '0) ? '0 : kme_pkg::NODE_W'(nodes - 1'b1);
                     taken_ff     <= '0;
                     iter_ff      <= '0;
                     have_last_ff <= 1'b0;
                     state_ff     <= T_CHECK;
                  end
               end
            end
            T_CHECK: begin
               if (uf_sts.ready) begin
                  if (iter_ff == fill_ff || taken_ff == target_ff) begin
                     state_ff <= T_FINISH;
                  end else begin
                     scan_ff   <= '0;
                     rd_vld_ff <= 1'b0;
                     found_ff  <= 1'b0;
                     state_ff  <= T_SCAN;
                  end
               end
            end
            T_SCAN: begin
               // issue the next read
               if (scan_ff != fill_ff) begin
                  rd_vld_ff <= 1'b1;
                  rd_idx_ff <= scan_ff[kme_pkg::EDGE_AW-1:0];
                  scan_ff   <= scan_ff + 1'b1;
               end else begin
                  rd_vld_ff <= 1'b0;
               end
               // strict compare keeps the earliest of equal weights
               if (rd_vld_ff && edge_fresh
                   && (!found_ff || edge_rd.wt < best_ff.wt)) begin
                  best_ff     <= edge_rd;
                  best_idx_ff <= rd_idx_ff;
                  found_ff    <= 1'b1;
               end
               if (scan_done) begin
                  have_last_ff <= 1'b1;
                  last_wt_ff   <= best_ff.wt;
                  last_idx_ff  <= best_idx_ff;
                  iter_ff      <= iter_ff + 1'b1;
                  state_ff     <= T_FIND;
               end
            end
            T_FIND: begin
               if (uf_sts.ready) begin
                  if (uf_sts.differ) begin
                     // previous tree edge is now known not to be the final one
                     taken_ff    <= taken_ff + 1'b1;
                     pend_ff     <= best_ff;
                     pend_vld_ff <= 1'b1;
                     if (pend_vld_ff) begin
                        rsp_data_ff  <= '{tree_src: pend_ff.src, tree_dst: pend_ff.dst,
                                          tree_weight: pend_ff.wt, overflowed: drop_ff,
                                          last_result: 1'b0};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= T_EMIT;
                     end else begin
                        state_ff <= T_JOIN;
                     end
                  end else begin
                     state_ff <= T_CHECK;
                  end
               end
            end
            T_EMIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= T_JOIN;
               end
            end
            T_JOIN: begin
               state_ff <= T_CHECK;
            end
            T_FINISH: begin
               if (pend_vld_ff) begin
                  rsp_data_ff  <= '{tree_src: pend_ff.src, tree_dst: pend_ff.dst,
                                    tree_weight: pend_ff.wt, overflowed: drop_ff,
                                    last_result: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_LAST_EMIT;
               end else begin
                  state_ff <= T_RESTART;
               end
            end
            T_LAST_EMIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= T_RESTART;
               end
            end
            T_RESTART: begin
               fill_ff     <= '0;
               drop_ff     <= 1'b0;
               pend_vld_ff <= 1'b0;
               state_ff    <= T_CLEAR;
            end
            default: begin
               state_ff <= T_CLEAR;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/kme_checker.sv
`include "kruskal_mst_engine_assert.svh"

module kme_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input kme_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready
);

   // a pending response is not withdrawn
   `KME_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid)

   // requests and responses never overlap
   `KME_ASSERT(a_no_overlap, !(req_ready && rsp_valid))

   // reset leaves no response pending
   `KME_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)

   // the final edge starts a run, so no request follows at once
   `KME_ASSERT(a_run_busy, (req_valid && req_ready && req_data.last_edge) |=> !req_ready)

endmodule

bind kruskal_mst_engine kme_checker u_kme_checker (.*);

>>> tb/tb_kruskal_mst_engine.sv
module tb_kruskal_mst_engine;

   localparam int WATCH_LIMIT = 400000;
   localparam int SETTLE_CYC  = 420;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   kme_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   kme_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en;
   logic [kme_pkg::CNT_W-1:0] csr_wr_data;

   kruskal_mst_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   kme_pkg::edge_type         stored_edges [kme_pkg::MAX_EDGES];
   int                        stored_fill;
   bit                        store_dropped;
   logic [kme_pkg::CNT_W-1:0] node_count_q;
   kme_pkg::rsp_type          tree_q [$];

   int  mismatches;
   int  requests_sent;
   int  tree_edges_seen;
   int  graphs_done;
   int  quiet_cycles;
   bit  gaps_on;
   bit  hold_req;
   bit  hold_ack;
   int  hold_left;
   int  stall_left;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // spanning tree of the stored graph, pushed as expected responses
   function automatic void predict_tree(input int nodes);
      int order [kme_pkg::MAX_EDGES];
      int parent [kme_pkg::MAX_NODES];
      int i, j, k, ra, rb, target, taken, first_idx;
      kme_pkg::rsp_type r;
      for (i = 0; i < stored_fill; i++) begin
         k = i;
         j = i;
         while (j > 0 && stored_edges[order[j-1]].wt > stored_edges[k].wt) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = k;
      end
      for (i = 0; i < kme_pkg::MAX_NODES; i++) parent[i] = i;
      target = (nodes > 0) ? nodes - 1 : 0;
      taken = 0;
      first_idx = tree_q.size();
      for (i = 0; i < stored_fill && taken < target; i++) begin
         ra = stored_edges[order[i]].src;
         while (parent[ra] != ra) ra = parent[ra];
         rb = stored_edges[order[i]].dst;
         while (parent[rb] != rb) rb = parent[rb];
         if (ra != rb) begin
            r.tree_src    = stored_edges[order[i]].src;
            r.tree_dst    = stored_edges[order[i]].dst;
            r.tree_weight = stored_edges[order[i]].wt;
            r.overflowed  = store_dropped;
            r.last_result = 1'b0;
            tree_q.push_back(r);
            parent[rb] = ra;
            taken++;
         end
      end
      if (tree_q.size() > first_idx) tree_q[tree_q.size()-1].last_result = 1'b1;
      stored_fill = 0;
      store_dropped = 1'b0;
      graphs_done++;
   endfunction

   // monitor: config, requests and responses sampled at the rising edge
   always @(posedge clock) begin
      int nodes;
      kme_pkg::rsp_type exp_r;
      if (reset) begin
         node_count_q = kme_pkg::CNT_W'(kme_pkg::MAX_NODES);
         stored_fill = 0;
         store_dropped = 1'b0;
      end else begin
         if (csr_wr_en) node_count_q = csr_wr_data;
         if (req_valid && req_ready) begin
            nodes = (node_count_q > kme_pkg::MAX_NODES) ? kme_pkg::MAX_NODES
                                                        : int'(node_count_q);
            if (req_data.src_node != req_data.dst_node && req_data.src_node < nodes
                && req_data.dst_node < nodes) begin
               if (stored_fill < kme_pkg::MAX_EDGES) begin
                  stored_edges[stored_fill].src = (req_data.src_node < req_data.dst_node)
                     ? req_data.src_node : req_data.dst_node;
                  stored_edges[stored_fill].dst = (req_data.src_node < req_data.dst_node)
                     ? req_data.dst_node : req_data.src_node;
                  stored_edges[stored_fill].wt = req_data.edge_weight;
                  stored_fill++;
               end else begin
                  store_dropped = 1'b1;
               end
            end
            if (req_data.last_edge) predict_tree(nodes);
         end
         if (rsp_valid && rsp_ready) begin
            tree_edges_seen++;
            if (tree_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected tree edge %0d-%0d w=%0d", rsp_data.tree_src,
                           rsp_data.tree_dst, rsp_data.tree_weight);
            end else begin
               exp_r = tree_q.pop_front();
               if (rsp_data.tree_src !== exp_r.tree_src
                   || rsp_data.tree_dst !== exp_r.tree_dst
                   || rsp_data.tree_weight !== exp_r.tree_weight
                   || rsp_data.overflowed !== exp_r.overflowed
                   || rsp_data.last_result !== exp_r.last_result) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp %0d-%0d w=%0d ovf=%b last=%b",
                               " got %0d-%0d w=%0d ovf=%b last=%b"},
                              exp_r.tree_src, exp_r.tree_dst, exp_r.tree_weight,
                              exp_r.overflowed, exp_r.last_result, rsp_data.tree_src,
                              rsp_data.tree_dst, rsp_data.tree_weight, rsp_data.overflowed,
                              rsp_data.last_result);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired, %0d tree edges outstanding", tree_q.size());
            $display("tb_kruskal_mst_engine NOT OK");
            $finish;
         end
      end
   end

   // response side: random stalls and the long hold-off
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_left = 600;
         hold_ack = hold_req;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) < 3) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // offer one request and wait for it to be taken
   task automatic send_edge(input logic [5:0] s, input logic [5:0] d,
                            input logic [15:0] w, input bit last);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 9) < 4)
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data.src_node <= s;
      req_data.dst_node <= d;
      req_data.edge_weight <= w;
      req_data.last_edge <= last;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic end_requests();
      @(negedge clock) req_valid <= 1'b0;
   endtask

   // wait for all tree edges, then the SETTLE_CYC delay, then for requests to be taken again
   task automatic wait_idle();
      while (tree_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [kme_pkg::CNT_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   // random graph over nodes 0..span, a little out-of-range noise
   task automatic send_graph(input int n_edges, input int span);
      logic [5:0] s, d;
      logic [15:0] w;
      for (int i = 0; i < n_edges; i++) begin
         s = 6'($urandom_range(0, span));
         d = 6'($urandom_range(0, span));
         if ($urandom_range(0, 9) == 0) s = 6'($urandom_range(0, 63));
         if ($urandom_range(0, 3) == 0) w = 16'($urandom_range(0, 3));
         else w = 16'($urandom);
         send_edge(s, d, w, i == n_edges - 1);
      end
   endtask

   // extremes, ties, self-loops, range drops, empty tree, count change
   task automatic test_directed();
      gaps_on = 1'b0;
      send_edge(6'd0, 6'd63, 16'h8000, 1'b0);
      send_edge(6'd63, 6'd1, 16'h7fff, 1'b0);
      send_edge(6'd5, 6'd5, 16'h0000, 1'b0);
      send_edge(6'd1, 6'd0, 16'h0005, 1'b0);
      send_edge(6'd2, 6'd1, 16'h0005, 1'b0);
      send_edge(6'd0, 6'd2, 16'h0005, 1'b0);
      send_edge(6'd2, 6'd3, 16'hffff, 1'b1);
      end_requests();
      wait_idle();
      // nodes at or above the count are dropped, count changed mid-load
      write_node_count(7'd4);
      send_edge(6'd0, 6'd4, 16'h0001, 1'b0);
      send_edge(6'd3, 6'd2, 16'h0002, 1'b0);
      send_edge(6'd0, 6'd1, 16'h0003, 1'b0);
      end_requests();
      wait_idle();
      write_node_count(7'd127);
      send_edge(6'd40, 6'd50, 16'h0004, 1'b0);
      send_edge(6'd1, 6'd2, 16'h0003, 1'b1);
      end_requests();
      wait_idle();
      // empty tree: a lone self-loop as the last edge
      send_edge(6'd9, 6'd9, 16'h1234, 1'b1);
      end_requests();
      wait_idle();
      write_node_count(7'd1);
      send_edge(6'd0, 6'd0, 16'h0001, 1'b0);
      send_edge(6'd0, 6'd1, 16'h0001, 1'b1);
      end_requests();
      wait_idle();
      write_node_count(7'd0);
      send_edge(6'd0, 6'd1, 16'h0001, 1'b1);
      end_requests();
      wait_idle();
      write_node_count(7'd2);
      send_edge(6'd1, 6'd0, 16'h0000, 1'b0);
      send_edge(6'd0, 6'd1, 16'hffff, 1'b1);
      end_requests();
      wait_idle();
   endtask

   // random graphs over several counts, gaps on both sides
   task automatic test_random_graphs();
      logic [kme_pkg::CNT_W-1:0] nc;
      int n_edges;
      while (requests_sent < 185) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 7))
            0: nc = 7'd64;
            1: nc = 7'd127;
            2: nc = kme_pkg::CNT_W'($urandom_range(0, 2));
            default: nc = kme_pkg::CNT_W'($urandom_range(3, 12));
         endcase
         write_node_count(nc);
         n_edges = (nc >= 64) ? $urandom_range(20, 40) : $urandom_range(3, 14);
         send_graph(n_edges, (nc > 63) ? 63 : ((nc == 0) ? 1 : nc - 1 + (nc < 3)));
         end_requests();
         wait_idle();
      end
   endtask

   // receiver holds off while the next graph is offered
   task automatic test_back_pressure();
      gaps_on = 1'b0;
      write_node_count(7'd20);
      hold_req = !hold_req;
      send_graph(14, 19);
      send_graph(8, 19);
      end_requests();
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      requests_sent = 0;
      gaps_on = 1'b0;
      hold_req = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (!req_ready) @(posedge clock);
      test_directed();
      test_random_graphs();
      test_back_pressure();
      wait_idle();
      $display("covered %0d requests over %0d graphs, %0d tree edges checked",
               requests_sent, graphs_done, tree_edges_seen);
      $display("counts 0,1,2,4,20,64,127, ties and extremes, long response hold-off");
      if (mismatches == 0 && tree_q.size() == 0) begin
         $display("tb_kruskal_mst_engine OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_kruskal_mst_engine NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kme_pkg.sv
hw/rtl/kme_ram.sv
hw/rtl/kme_uf.sv
hw/rtl/kruskal_mst_engine.sv
hw/rtl/kme_checker.sv
tb/tb_kruskal_mst_engine.sv
